// ----- hw/rtl/mrfr_pkg.sv -----
package mrfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3;
    localparam int CFG_ADDR_W = 2;

    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd3;

    localparam logic [BYTE_W-1:0] RST_ACK_BYTE      = 8'd6;
    localparam logic [BYTE_W-1:0] RST_NAK_BYTE      = 8'd21;
    localparam logic [BYTE_W-1:0] RST_CRC_FAIL_BYTE = 8'd81;

    localparam logic [CFG_ADDR_W-1:0] REG_ACK_ONLY_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACK_BYTE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NAK_BYTE      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CRC_FAIL_BYTE = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_PAYLOAD = 3'd0,
        EV_GOOD    = 3'd1,
        EV_BADSUM  = 3'd2,
        EV_ACK     = 3'd3,
        EV_NAK     = 3'd4,
        EV_CRCFAIL = 3'd5,
        EV_LENERR  = 3'd6
    } event_t;

    typedef struct packed {
        logic              ack_only_mode;
        logic [BYTE_W-1:0] ack_byte;
        logic [BYTE_W-1:0] nak_byte;
        logic [BYTE_W-1:0] crc_fail_byte;
    } cfg_t;

    typedef struct packed {
        event_t            event_res;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_length;
    } result_t;

endpackage

// ----- hw/rtl/mrfr_cfg_regs.sv -----
module mrfr_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mrfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mrfr_pkg::BYTE_W-1:0]        cfg_wdata,
    output mrfr_pkg::cfg_t                     cfg
);
    import mrfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ACK_ONLY_MODE: cfg_next.ack_only_mode = cfg_wdata[0];
                REG_ACK_BYTE:      cfg_next.ack_byte      = cfg_wdata;
                REG_NAK_BYTE:      cfg_next.nak_byte      = cfg_wdata;
                REG_CRC_FAIL_BYTE: cfg_next.crc_fail_byte = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_only_mode <= 1'b0;
            cfg_reg.ack_byte      <= RST_ACK_BYTE;
            cfg_reg.nak_byte      <= RST_NAK_BYTE;
            cfg_reg.crc_fail_byte <= RST_CRC_FAIL_BYTE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/mrfr_parser.sv -----
module mrfr_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mrfr_pkg::cfg_t              cfg,
    input  logic                        advance,
    input  logic [mrfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                        res_valid,
    output mrfr_pkg::result_t           res
);
    import mrfr_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        sum_next    = sum_reg;
        res_valid   = 1'b0;
        res.event_res    = EV_PAYLOAD;
        res.byte_value   = '0;
        res.byte_index   = '0;
        res.frame_length = '0;
        unique case (phase_reg)
            PH_LEN: begin
                length_next = rx_byte;
                count_next  = 8'd2;
                sum_next    = sum_reg + rx_byte;
                if (rx_byte < MIN_FRAME_LEN) begin
                    phase_next       = PH_IDLE;
                    count_next       = '0;
                    res_valid        = 1'b1;
                    res.event_res    = EV_LENERR;
                    res.frame_length = rx_byte;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                res_valid        = 1'b1;
                res.byte_value   = rx_byte;
                res.frame_length = length_reg;
                if (count_inc == length_reg) begin
                    phase_next    = PH_IDLE;
                    count_next    = '0;
                    res.event_res = (rx_byte == sum_reg) ? EV_GOOD : EV_BADSUM;
                end else begin
                    count_next     = count_inc;
                    sum_next       = sum_reg + rx_byte;
                    res.byte_index = count_inc - MIN_FRAME_LEN;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                count_next = '0;
                if (rx_byte == cfg.ack_byte) begin
                    length_next = '0;
                    sum_next    = cfg.ack_byte;
                    if (cfg.ack_only_mode) begin
                        res_valid     = 1'b1;
                        res.event_res = EV_ACK;
                    end else begin
                        count_next = 8'd1;
                        phase_next = PH_LEN;
                    end
                end else if (rx_byte == cfg.nak_byte) begin
                    res_valid     = 1'b1;
                    res.event_res = EV_NAK;
                end else if (rx_byte == cfg.crc_fail_byte) begin
                    res_valid     = 1'b1;
                    res.event_res = EV_CRCFAIL;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            length_reg <= '0;
            sum_reg    <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            sum_reg    <= sum_next;
        end
    end

    a_data_len_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> length_reg >= MIN_FRAME_LEN && count_reg < length_reg)
        else $error("payload phase with inconsistent length or count");

    a_len_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LEN |-> count_reg == 8'd1 && length_reg == '0)
        else $error("length phase without a fresh frame start");

endmodule

// ----- hw/rtl/mrfr_out_fifo.sv -----
module mrfr_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  mrfr_pkg::result_t wr_data,
    output logic              wr_ready,
    output logic              rd_valid,
    input  logic              rd_ready,
    output mrfr_pkg::result_t rd_data
);
    import mrfr_pkg::*;

    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> count_reg != 2'd2)
        else $error("result written into a full output buffer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3 && ((count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("output buffer count and pointers disagree");

endmodule

// ----- hw/rtl/meter_response_frame_receiver.sv -----
// Receiver for response frames from an energy-meter chip.
// Bytes from the UART enter on the s_ channel, one transaction per byte
// in s_tdata. Unless ack-only mode is set, a byte equal to the acknowledge register starts
// a frame, followed by the length byte, the payload and an additive checksum.
// Each result leaves on the m_ channel: m_tuser carries the event code,
// m_tdata the byte value, the payload index and the frame length.
// Payload bytes are passed out as they arrive, and the frame closes with
// a good or bad checksum event, or a length error for a length below 3.
// Configuration registers are written through cfg_wr_en, cfg_addr and cfg_wdata;
// the user must write them only while no byte is in flight, as the block does not enforce it.
// A byte is registered on acceptance and its result, if it has one, is
// written into a two-entry output buffer once the buffer has room, and
// m_tvalid rises when the buffer holds a result.
// One byte is accepted every cycle while the
// output buffer has room; when the receiver stalls, up to two results
// are held and one more byte waits in the input register before s_tready
// falls. A synchronous reset returns the receiver to idle and loads the
// default acknowledge, NAK and CRC-fail codes.
module meter_response_frame_receiver (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // byte_value, byte_index, frame_length
    output logic [2:0]                         m_tuser,   // event_res
    input  logic                               cfg_wr_en,
    input  logic [mrfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mrfr_pkg::BYTE_W-1:0]        cfg_wdata
);
    import mrfr_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              fifo_ready;
    logic              advance;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    mrfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && fifo_ready;
    assign s_tready = !in_valid_reg || fifo_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    mrfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .advance   (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mrfr_out_fifo u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (advance && res_valid),
        .wr_data  (res),
        .wr_ready (fifo_ready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res)
    );

    assign m_tuser = out_res.event_res;
    assign m_tdata = {out_res.frame_length, out_res.byte_index, out_res.byte_value};

endmodule
